// ===== design/sspc_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper speed panel controller - shared definitions
// Field widths, register indexes, reset values, display codes and the
// reciprocal constants used for the fixed divisions.
// ----------------------------------------------------------------------------
package sspc_pkg;

    // Field widths
    localparam int SPEED_W    = 17;
    localparam int VEL_W      = 23;
    localparam int SCALE_W    = 24;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int CHAR_W     = 7;
    localparam int DOT_W      = 3;
    localparam int VAL_W      = 11;   // rounded display value, at most 1200
    localparam int BAND_W     = 10;   // largest band is 1000
    localparam int Q10_W      = 15;   // (speed + 5) / 10
    localparam int Q100_W     = 12;   // (speed + 50) / 100

    // Port widths
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_REPEAT_DELAY    = 3'd0,
        CFG_REPEAT_INTERVAL = 3'd1,
        CFG_MODE_THRESHOLD  = 3'd2,
        CFG_MIN_SPEED       = 3'd3,
        CFG_MAX_SPEED       = 3'd4,
        CFG_VEL_SCALE       = 3'd5
    } t_cfg_idx;

    // Register reset values
    localparam logic [MS_W-1:0]    RST_REPEAT_DELAY    = 16'd400;
    localparam logic [MS_W-1:0]    RST_REPEAT_INTERVAL = 16'd80;
    localparam logic [SPEED_W-1:0] RST_MODE_THRESHOLD  = 17'd20000;
    localparam logic [SPEED_W-1:0] RST_MIN_SPEED       = 17'd3;
    localparam logic [SPEED_W-1:0] RST_MAX_SPEED       = 17'd120000;
    localparam logic [SCALE_W-1:0] RST_VEL_SCALE       = 24'd6254931;

    // Speed bands
    localparam logic [SPEED_W-1:0] BAND_EDGE_10   = 17'd10;
    localparam logic [SPEED_W-1:0] BAND_EDGE_100  = 17'd100;
    localparam logic [SPEED_W-1:0] BAND_EDGE_5000 = 17'd5000;
    localparam logic [BAND_W-1:0]  BAND_1         = 10'd1;
    localparam logic [BAND_W-1:0]  BAND_10        = 10'd10;
    localparam logic [BAND_W-1:0]  BAND_100       = 10'd100;
    localparam logic [BAND_W-1:0]  BAND_1000      = 10'd1000;

    // Display range edges
    localparam logic [SPEED_W-1:0] DISP_EDGE_100    = 17'd100;
    localparam logic [SPEED_W-1:0] DISP_EDGE_1000   = 17'd1000;
    localparam logic [SPEED_W-1:0] DISP_EDGE_10000  = 17'd10000;
    localparam logic [SPEED_W-1:0] DISP_EDGE_100000 = 17'd100000;

    // Display value clamps
    localparam logic [VAL_W-1:0] VAL_10   = 11'd10;
    localparam logic [VAL_W-1:0] VAL_99   = 11'd99;
    localparam logic [VAL_W-1:0] VAL_100  = 11'd100;
    localparam logic [VAL_W-1:0] VAL_999  = 11'd999;
    localparam logic [VAL_W-1:0] VAL_1000 = 11'd1000;
    localparam logic [VAL_W-1:0] VAL_1200 = 11'd1200;

    // Rounding offsets and reciprocals, exact over the ranges used:
    // (x * 104858) >> 20 == x / 10 for x < 2^18
    // (x * 167773) >> 24 == x / 100 for x < 199728
    // (v * 6554) >> 16 == v / 10 and (v * 1311) >> 17 == v / 100 for v < 2^11
    localparam logic [SPEED_W:0] ROUND_10   = 18'd5;
    localparam logic [SPEED_W:0] ROUND_100  = 18'd50;
    localparam logic [16:0]      RECIP_S10  = 17'd104858;
    localparam logic [17:0]      RECIP_S100 = 18'd167773;
    localparam logic [12:0]      RECIP_V10  = 13'd6554;
    localparam logic [10:0]      RECIP_V100 = 11'd1311;

    // Velocity word limits
    localparam logic [VEL_W-1:0] VEL_MIN = 23'd1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_F     = 7'h46;
    localparam logic [CHAR_W-1:0] CH_R     = 7'h52;
    localparam logic [CHAR_W-1:0] CH_E     = 7'h45;

    // Decimal point positions
    localparam logic [DOT_W-1:0] DOT_DIGIT0 = 3'd0;
    localparam logic [DOT_W-1:0] DOT_DIGIT1 = 3'd1;
    localparam logic [DOT_W-1:0] DOT_NONE   = 3'd4;

    // Display formats
    typedef enum logic [2:0] {
        FMT_FREE,       // freewheel text
        FMT_DASH,       // stopped
        FMT_TENTHS_LO,  // 1..99, leading zero, dot on digit 0
        FMT_TENTHS_MID, // 100..999, dot on digit 1
        FMT_TENTHS_HI,  // 1000..9999, dot on digit 1
        FMT_UNITS_MID,  // 10000..99999, no dot
        FMT_UNITS_HI    // 100000 and up, no dot
    } t_fmt;

    // Hold-to-repeat tracking for one button
    typedef struct packed {
        logic              held;
        logic              rep;
        logic [TIME_W-1:0] press;
        logic [TIME_W-1:0] last;
    } t_btn;

    typedef struct packed {
        t_btn nxt;
        logic step;
    } t_btn_res;

endpackage

// ===== design/stepper_speed_panel_controller.sv =====
// ----------------------------------------------------------------------------
// Stepper speed panel controller
// Button poll in, speed, driver velocity word, drive flags and a four
// character display image out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one button poll per beat; m_axis returns exactly one
//   result beat for each poll, in order. Registers are written through the
//   plain write port (i_cfg_we / i_cfg_addr / i_cfg_wdata), only while no
//   poll is in flight; indexes 6 and 7 are ignored.
//   Throughput: one poll per cycle while m_axis is not stalled. A poll
//   is registered in order by the input register, then the state update,
//   the velocity multiply and rounding divides, clamping, and the digit
//   split into the output register. The state update needs no pause
//   between beats, so consecutive polls can follow each other with no gap.
//   Stall: each stage holds its beat while the one after it is full and
//   stalled, so the pipeline fills up behind a stalled m_axis and
//   s_axis_tready falls only once every stage is occupied.
//   Reset (i_rst_n low at a rising edge): all stages empty, speed 0,
//   freewheel and drive mode off, both buttons released, registers back
//   to their default values.
// ----------------------------------------------------------------------------
module stepper_speed_panel_controller
    import sspc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // poll stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // from bit 0: up_pressed, down_pressed, select_pressed, now_ms[31:0], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // from bit 0: speed_crpm[16:0], velocity_word[22:0], coast_active,
    // torque_mode, char0..char3[6:0] each, dot_position[2:0], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MS_W-1:0]    r_rep_delay;
    logic [MS_W-1:0]    r_rep_interval;
    logic [SPEED_W-1:0] r_mode_thr;
    logic [SPEED_W-1:0] r_min_speed;
    logic [SPEED_W-1:0] r_max_speed;
    logic [SCALE_W-1:0] r_vel_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_delay    <= RST_REPEAT_DELAY;
            r_rep_interval <= RST_REPEAT_INTERVAL;
            r_mode_thr     <= RST_MODE_THRESHOLD;
            r_min_speed    <= RST_MIN_SPEED;
            r_max_speed    <= RST_MAX_SPEED;
            r_vel_scale    <= RST_VEL_SCALE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_REPEAT_DELAY:    r_rep_delay    <= i_cfg_wdata[MS_W-1:0];
                CFG_REPEAT_INTERVAL: r_rep_interval <= i_cfg_wdata[MS_W-1:0];
                CFG_MODE_THRESHOLD:  r_mode_thr     <= i_cfg_wdata[SPEED_W-1:0];
                CFG_MIN_SPEED:       r_min_speed    <= i_cfg_wdata[SPEED_W-1:0];
                CFG_MAX_SPEED:       r_max_speed    <= i_cfg_wdata[SPEED_W-1:0];
                CFG_VEL_SCALE:       r_vel_scale    <= i_cfg_wdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [BAND_W-1:0] band_of(input logic [SPEED_W-1:0] s);
        logic [BAND_W-1:0] b;
        if (s < BAND_EDGE_10)
            b = BAND_1;
        else if (s < BAND_EDGE_100)
            b = BAND_10;
        else if (s < BAND_EDGE_5000)
            b = BAND_100;
        else
            b = BAND_1000;
        return b;
    endfunction

    // Up from stop takes the minimum as it stands, without the max clamp.
    function automatic logic [SPEED_W-1:0] step_up(input logic [SPEED_W-1:0] s,
                                                   input logic [SPEED_W-1:0] lo,
                                                   input logic [SPEED_W-1:0] hi);
        logic [SPEED_W:0]   t;
        logic [SPEED_W-1:0] r;
        t = {1'b0, s} + {{(SPEED_W+1-BAND_W){1'b0}}, band_of(s)};
        if (s == '0)
            r = lo;
        else if (t < {1'b0, hi})
            r = t[SPEED_W-1:0];
        else
            r = hi;
        return r;
    endfunction

    function automatic logic [SPEED_W-1:0] step_down(input logic [SPEED_W-1:0] s);
        logic [SPEED_W-1:0] b;
        b = {{(SPEED_W-BAND_W){1'b0}}, band_of(s)};
        return (s > b) ? (s - b) : '0;
    endfunction

    // Hold-to-repeat: step on press, then after the hold delay step once per
    // interval. Time differences wrap modulo 2^32.
    function automatic t_btn_res btn_next(input t_btn              cur,
                                          input logic              pressed,
                                          input logic [TIME_W-1:0] now,
                                          input logic [MS_W-1:0]   dly,
                                          input logic [MS_W-1:0]   ivl);
        t_btn_res res;
        logic     rep;
        res.nxt  = cur;
        res.step = 1'b0;
        rep      = 1'b0;
        if (pressed && !cur.held) begin
            res.nxt.held  = 1'b1;
            res.nxt.rep   = 1'b0;
            res.nxt.press = now;
            res.nxt.last  = now;
            res.step      = 1'b1;
        end else if (pressed) begin
            rep = cur.rep
                || ((now - cur.press) >= {{(TIME_W-MS_W){1'b0}}, dly});
            res.nxt.rep = rep;
            if (rep && ((now - cur.last) >= {{(TIME_W-MS_W){1'b0}}, ivl})) begin
                res.step     = 1'b1;
                res.nxt.last = now;
            end
        end else begin
            res.nxt.held = 1'b0;
            res.nxt.rep  = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] clamp_val(input logic [Q10_W-1:0] x,
                                                   input logic [VAL_W-1:0] lo,
                                                   input logic [VAL_W-1:0] hi);
        logic [VAL_W-1:0] r;
        if (x < {{(Q10_W-VAL_W){1'b0}}, lo})
            r = lo;
        else if (x > {{(Q10_W-VAL_W){1'b0}}, hi})
            r = hi;
        else
            r = x[VAL_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stage advance: a stage takes a new beat when it is empty or its
    // contents move on in the same cycle.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5 = !r_v5 || m_axis_tready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign s_axis_tready = w_en1;
    assign m_axis_tvalid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic              r_p1_up;
    logic              r_p1_down;
    logic              r_p1_sel;
    logic [TIME_W-1:0] r_p1_now;

    always_ff @(posedge i_clk) begin
        if (w_en1 && s_axis_tvalid) begin
            r_p1_up   <= s_axis_tdata[0];
            r_p1_down <= s_axis_tdata[1];
            r_p1_sel  <= s_axis_tdata[2];
            r_p1_now  <= s_axis_tdata[TIME_W+2:3];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: state update. The state registers only move when a beat
    // enters this stage, so while it is occupied they hold that beat's
    // speed and flags and serve as its payload.
    // ------------------------------------------------------------------
    logic [SPEED_W-1:0] r_speed, n_speed;
    logic               r_coast, n_coast;
    logic               r_mode, n_mode;
    logic               r_sel_prev;
    t_btn               r_up_btn, r_dn_btn;
    t_btn_res           w_up_res, w_dn_res;

    assign w_up_res = btn_next(r_up_btn, r_p1_up, r_p1_now, r_rep_delay, r_rep_interval);
    assign w_dn_res = btn_next(r_dn_btn, r_p1_down, r_p1_now, r_rep_delay, r_rep_interval);

    // Select edge first, then up, then down. Any step clears freewheel; the
    // drive mode follows only a step that may change the speed.
    always_comb begin
        n_speed = r_speed;
        n_coast = r_coast;
        n_mode  = r_mode;
        if (r_p1_sel && !r_sel_prev) begin
            n_speed = '0;
            n_coast = 1'b1;
            n_mode  = (r_mode_thr == '0);
        end
        if (w_up_res.step) begin
            n_coast = 1'b0;
            n_speed = step_up(n_speed, r_min_speed, r_max_speed);
            n_mode  = (n_speed >= r_mode_thr);
        end
        if (w_dn_res.step) begin
            n_coast = 1'b0;
            if (n_speed != '0) begin
                n_speed = step_down(n_speed);
                n_mode  = (n_speed >= r_mode_thr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= '0;
            r_coast    <= 1'b0;
            r_mode     <= 1'b0;
            r_sel_prev <= 1'b0;
            r_up_btn   <= '0;
            r_dn_btn   <= '0;
        end else if (w_en2 && r_v1) begin
            r_speed    <= n_speed;
            r_coast    <= n_coast;
            r_mode     <= n_mode;
            r_sel_prev <= r_p1_sel;
            r_up_btn   <= w_up_res.nxt;
            r_dn_btn   <= w_dn_res.nxt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: velocity product and rounding divides by reciprocal
    // ------------------------------------------------------------------
    logic [SPEED_W:0]           w_s_r10;
    logic [SPEED_W:0]           w_s_r100;
    logic [34:0]                w_q10_prod;
    logic [35:0]                w_q100_prod;
    logic [SPEED_W+SCALE_W-1:0] w_vel_prod;

    assign w_s_r10     = {1'b0, r_speed} + ROUND_10;
    assign w_s_r100    = {1'b0, r_speed} + ROUND_100;
    assign w_q10_prod  = 35'(w_s_r10) * 35'(RECIP_S10);
    assign w_q100_prod = 36'(w_s_r100) * 36'(RECIP_S100);
    assign w_vel_prod  = (SPEED_W+SCALE_W)'(r_speed) * (SPEED_W+SCALE_W)'(r_vel_scale);

    logic [SPEED_W-1:0] r_p3_speed;
    logic               r_p3_coast;
    logic               r_p3_mode;
    logic [SPEED_W-1:0] r_p3_vel_raw;
    logic [Q10_W-1:0]   r_p3_q10;
    logic [Q100_W-1:0]  r_p3_q100;

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_v2) begin
            r_p3_speed   <= r_speed;
            r_p3_coast   <= r_coast;
            r_p3_mode    <= r_mode;
            r_p3_vel_raw <= w_vel_prod[SPEED_W+SCALE_W-1:SCALE_W];
            r_p3_q10     <= w_q10_prod[34:20];
            r_p3_q100    <= w_q100_prod[35:24];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: velocity clamp, display format and display value
    // ------------------------------------------------------------------
    logic [VEL_W-1:0] w_vel;
    t_fmt             w_fmt;
    logic [VAL_W-1:0] w_val;

    // The truncated product never exceeds 17 bits, so only the floor of
    // one needs enforcing; a stopped motor gives zero.
    always_comb begin
        if (r_p3_speed == '0)
            w_vel = '0;
        else if (r_p3_vel_raw == '0)
            w_vel = VEL_MIN;
        else
            w_vel = {{(VEL_W-SPEED_W){1'b0}}, r_p3_vel_raw};
    end

    always_comb begin
        w_val = '0;
        if (r_p3_coast) begin
            w_fmt = FMT_FREE;
        end else if (r_p3_speed == '0) begin
            w_fmt = FMT_DASH;
        end else if (r_p3_speed < DISP_EDGE_100) begin
            w_fmt = FMT_TENTHS_LO;
            w_val = r_p3_speed[VAL_W-1:0];
        end else if (r_p3_speed < DISP_EDGE_1000) begin
            w_fmt = FMT_TENTHS_MID;
            w_val = clamp_val(r_p3_q10, VAL_10, VAL_99);
        end else if (r_p3_speed < DISP_EDGE_10000) begin
            w_fmt = FMT_TENTHS_HI;
            w_val = clamp_val(r_p3_q10, VAL_100, VAL_999);
        end else if (r_p3_speed < DISP_EDGE_100000) begin
            w_fmt = FMT_UNITS_MID;
            w_val = clamp_val(Q10_W'(r_p3_q100), VAL_100, VAL_999);
        end else begin
            w_fmt = FMT_UNITS_HI;
            w_val = clamp_val(Q10_W'(r_p3_q100), VAL_1000, VAL_1200);
        end
    end

    logic [SPEED_W-1:0] r_p4_speed;
    logic [VEL_W-1:0]   r_p4_vel;
    logic               r_p4_coast;
    logic               r_p4_mode;
    t_fmt               r_p4_fmt;
    logic [VAL_W-1:0]   r_p4_val;

    always_ff @(posedge i_clk) begin
        if (w_en4 && r_v3) begin
            r_p4_speed <= r_p3_speed;
            r_p4_vel   <= w_vel;
            r_p4_coast <= r_p3_coast;
            r_p4_mode  <= r_p3_mode;
            r_p4_fmt   <= w_fmt;
            r_p4_val   <= w_val;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: split the value into decimal digits and build the text
    // ------------------------------------------------------------------
    logic [23:0]       w_v10_prod;
    logic [21:0]       w_v100_prod;
    logic [7:0]        w_q10v;
    logic [4:0]        w_q100v;
    logic              w_q1000v;
    logic [VAL_W-1:0]  w_rem0;
    logic [7:0]        w_rem1;
    logic [4:0]        w_rem2;
    logic [3:0]        w_d0, w_d1, w_d2;

    assign w_v10_prod  = 24'(r_p4_val) * 24'(RECIP_V10);
    assign w_v100_prod = 22'(r_p4_val) * 22'(RECIP_V100);
    assign w_q10v      = w_v10_prod[23:16];
    assign w_q100v     = w_v100_prod[21:17];
    assign w_q1000v    = (w_q100v >= 5'd10);

    assign w_rem0 = r_p4_val - (VAL_W'(w_q10v) * VAL_W'(4'd10));
    assign w_rem1 = w_q10v - (8'(w_q100v) * 8'd10);
    assign w_rem2 = w_q100v - (w_q1000v ? 5'd10 : 5'd0);
    assign w_d0   = w_rem0[3:0];
    assign w_d1   = w_rem1[3:0];
    assign w_d2   = w_rem2[3:0];

    logic [CHAR_W-1:0] w_ch0, w_ch1, w_ch2, w_ch3;
    logic [CHAR_W-1:0] w_dig0, w_dig1, w_dig2, w_dig3;
    logic [DOT_W-1:0]  w_dot;

    assign w_dig0 = CH_ZERO + {3'b000, w_d0};
    assign w_dig1 = CH_ZERO + {3'b000, w_d1};
    assign w_dig2 = CH_ZERO + {3'b000, w_d2};
    assign w_dig3 = CH_ZERO + {6'b000000, w_q1000v};

    always_comb begin
        w_dot = DOT_NONE;
        case (r_p4_fmt)
            FMT_FREE: begin
                w_ch0 = CH_F;    w_ch1 = CH_R;    w_ch2 = CH_E;    w_ch3 = CH_E;
            end
            FMT_TENTHS_LO: begin
                w_ch0 = CH_ZERO;  w_ch1 = w_dig1; w_ch2 = w_dig0; w_ch3 = CH_SPACE;
                w_dot = DOT_DIGIT0;
            end
            FMT_TENTHS_MID: begin
                w_ch0 = CH_SPACE; w_ch1 = w_dig1; w_ch2 = w_dig0; w_ch3 = CH_SPACE;
                w_dot = DOT_DIGIT1;
            end
            FMT_TENTHS_HI: begin
                w_ch0 = w_dig2;   w_ch1 = w_dig1; w_ch2 = w_dig0; w_ch3 = CH_SPACE;
                w_dot = DOT_DIGIT1;
            end
            FMT_UNITS_MID: begin
                w_ch0 = CH_SPACE; w_ch1 = w_dig2; w_ch2 = w_dig1; w_ch3 = w_dig0;
            end
            FMT_UNITS_HI: begin
                w_ch0 = w_dig3;   w_ch1 = w_dig2; w_ch2 = w_dig1; w_ch3 = w_dig0;
            end
            default: begin
                w_ch0 = CH_DASH;  w_ch1 = CH_DASH; w_ch2 = CH_DASH; w_ch3 = CH_DASH;
            end
        endcase
    end

    // Output register: holds the result beat until it is taken
    logic [OUT_TDATA_W-1:0] r_out_tdata;

    always_ff @(posedge i_clk) begin
        if (w_en5 && r_v4) begin
            r_out_tdata <= {7'b0000000, w_dot, w_ch3, w_ch2, w_ch1, w_ch0,
                            r_p4_mode, r_p4_coast, r_p4_vel, r_p4_speed};
        end
    end

    assign m_axis_tdata = r_out_tdata;

endmodule
